// ===== rtl/dns_name_text_to_wire_defines.svh =====
// Assertion macros for the domain name text to wire converter.
`ifndef DNS_NAME_TEXT_TO_WIRE_DEFINES_SVH
`define DNS_NAME_TEXT_TO_WIRE_DEFINES_SVH

`ifndef SYNTHESIS
`define DNTW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dntw: assertion failed");
`define DNTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dntw: assertion failed");
`else
`define DNTW_ASSERT(lbl, prop)
`define DNTW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/dntw_pkg.sv =====
// Shared types and constants for the domain name text to wire converter.
`timescale 1ns / 1ps

package dntw_pkg;

  localparam logic [7:0] NAME_MAX  = 8'd255;
  localparam logic [7:0] LABEL_MAX = 8'd63;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NAME_LONG  = 3'd1;
  localparam logic [2:0] ERR_EMPTY      = 3'd2;
  localparam logic [2:0] ERR_LABEL_LONG = 3'd3;
  localparam logic [2:0] ERR_BAD_ESC    = 3'd4;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_DIG1,
    MODE_DIG2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_LEN,
    KIND_DONE,
    KIND_ERROR
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] offset;
    logic [7:0] value;
    logic [8:0] total_length;
    logic [2:0] error_code;
  } result_t;

  typedef struct packed {
    logic [1:0]       last_idx;
    result_t [3:0]    res;
  } bundle_t;

endpackage

// ===== rtl/dntw_front.sv =====
// Character parser: tracks label and escape state, builds result bundles.
`timescale 1ns / 1ps

module dntw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        ch_i,
  input  logic              last_i,
  output logic              push_o,
  output dntw_pkg::bundle_t bundle_o
);

  import dntw_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] ls_q, ls_d;
  logic [7:0] wp_q, wp_d;
  logic [6:0] esc_q, esc_d;
  logic [2:0] err_q, err_d;

  logic       is_dig;
  logic [3:0] dig;
  logic [9:0] esc_sum;
  logic [7:0] clen;

  logic       root;
  logic       cev_vld;
  result_t    cev;
  logic       fin_len_vld;
  logic [7:0] fin_len_off;
  logic [7:0] fin_len;
  logic [8:0] fin_tot;
  logic [7:0] fin_root_off;
  logic [2:0] fin_err;

  assign is_dig  = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign dig     = ch_i[3:0];
  assign esc_sum = {esc_q, 3'b000} + {2'b00, esc_q, 1'b0} + {6'd0, dig};
  assign clen    = wp_q - ls_q - 8'd1;

  always_comb begin
    mode_e      m;
    logic [2:0] e;
    logic [7:0] lsx;
    logic [7:0] wpx;
    logic [7:0] flen;
    mode_d       = mode_q;
    ls_d         = ls_q;
    wp_d         = wp_q;
    esc_d        = esc_q;
    err_d        = err_q;
    root         = 1'b0;
    cev_vld      = 1'b0;
    cev          = '{kind: KIND_DATA, offset: wp_q, value: ch_i, total_length: 9'd0,
                     error_code: ERR_NONE};
    fin_len_vld  = 1'b0;
    fin_len_off  = 8'd0;
    fin_len      = 8'd0;
    fin_tot      = 9'd0;
    fin_root_off = 8'd0;
    fin_err      = ERR_NONE;
    m            = MODE_NORMAL;
    e            = ERR_NONE;
    lsx          = 8'd0;
    wpx          = 8'd0;
    flen         = 8'd0;
    if (err_q == ERR_NONE) begin
      case (mode_q)
        MODE_NORMAL: begin
          if (last_i && ch_i == CH_DOT && wp_q == 8'd1 && ls_q == 8'd0) begin
            root = 1'b1;
          end else if (wp_q >= NAME_MAX) begin
            err_d = ERR_NAME_LONG;
          end else if (ch_i == CH_DOT) begin
            if (wp_q == ls_q + 8'd1) begin
              err_d = ERR_EMPTY;
            end else if (clen > LABEL_MAX) begin
              err_d = ERR_LABEL_LONG;
            end else begin
              cev_vld    = 1'b1;
              cev.kind   = KIND_LEN;
              cev.offset = ls_q;
              cev.value  = clen;
              ls_d       = wp_q;
              wp_d       = wp_q + 8'd1;
            end
          end else if (ch_i == CH_BSL) begin
            mode_d = MODE_ESC;
          end else begin
            cev_vld = 1'b1;
            wp_d    = wp_q + 8'd1;
          end
        end
        MODE_ESC: begin
          if (is_dig) begin
            esc_d  = {3'b000, dig};
            mode_d = MODE_DIG1;
          end else begin
            cev_vld = 1'b1;
            wp_d    = wp_q + 8'd1;
            mode_d  = MODE_NORMAL;
          end
        end
        MODE_DIG1: begin
          if (is_dig) begin
            esc_d  = esc_sum[6:0];
            mode_d = MODE_DIG2;
          end else begin
            err_d = ERR_BAD_ESC;
          end
        end
        MODE_DIG2: begin
          if (is_dig) begin
            cev_vld   = 1'b1;
            cev.value = (esc_sum > 10'd255) ? 8'd0 : esc_sum[7:0];
            wp_d      = wp_q + 8'd1;
            mode_d    = MODE_NORMAL;
            esc_d     = 7'd0;
          end else begin
            err_d = ERR_BAD_ESC;
          end
        end
        default: begin
          mode_d = MODE_NORMAL;
        end
      endcase
    end
    if (last_i && !root) begin
      e   = err_d;
      m   = mode_d;
      lsx = ls_d;
      wpx = wp_d;
      if (e == ERR_NONE && m != MODE_NORMAL) begin
        e = ERR_BAD_ESC;
      end
      if (e == ERR_NONE && {1'b0, wpx} != {1'b0, lsx} + 9'd1) begin
        flen = wpx - lsx - 8'd1;
        if (flen > LABEL_MAX) begin
          e = ERR_LABEL_LONG;
        end else begin
          fin_len_vld = 1'b1;
          fin_len_off = lsx;
          fin_len     = flen;
          lsx         = wpx;
        end
      end
      fin_tot = {1'b0, lsx} + 9'd1;
      if (e == ERR_NONE && fin_tot > {1'b0, NAME_MAX}) begin
        e = ERR_NAME_LONG;
      end
      fin_root_off = lsx;
      fin_err      = e;
    end
    if (last_i) begin
      mode_d = MODE_NORMAL;
      ls_d   = 8'd0;
      wp_d   = 8'd1;
      esc_d  = 7'd0;
      err_d  = ERR_NONE;
    end
  end

  always_comb begin
    logic [2:0] n;
    n        = 3'd0;
    bundle_o = '0;
    if (root) begin
      bundle_o.res[0] = '{kind: KIND_LEN, offset: 8'd0, value: 8'd0, total_length: 9'd0,
                          error_code: ERR_NONE};
      bundle_o.res[1] = '{kind: KIND_DONE, offset: 8'd0, value: 8'd0, total_length: 9'd1,
                          error_code: ERR_NONE};
      n = 3'd2;
    end else if (last_i && fin_err != ERR_NONE) begin
      bundle_o.res[0] = '{kind: KIND_ERROR, offset: 8'd0, value: 8'd0, total_length: 9'd0,
                          error_code: fin_err};
      n = 3'd1;
    end else begin
      if (cev_vld) begin
        bundle_o.res[n[1:0]] = cev;
        n = n + 3'd1;
      end
      if (last_i) begin
        if (fin_len_vld) begin
          bundle_o.res[n[1:0]] = '{kind: KIND_LEN, offset: fin_len_off, value: fin_len,
                                   total_length: 9'd0, error_code: ERR_NONE};
          n = n + 3'd1;
        end
        bundle_o.res[n[1:0]] = '{kind: KIND_LEN, offset: fin_root_off, value: 8'd0,
                                 total_length: 9'd0, error_code: ERR_NONE};
        n = n + 3'd1;
        bundle_o.res[n[1:0]] = '{kind: KIND_DONE, offset: 8'd0, value: 8'd0,
                                 total_length: fin_tot, error_code: ERR_NONE};
        n = n + 3'd1;
      end
    end
    bundle_o.last_idx = 2'(n - 3'd1);
    push_o            = accept_i && (n != 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      ls_q   <= 8'd0;
      wp_q   <= 8'd1;
      esc_q  <= 7'd0;
      err_q  <= ERR_NONE;
    end else if (accept_i) begin
      mode_q <= mode_d;
      ls_q   <= ls_d;
      wp_q   <= wp_d;
      esc_q  <= esc_d;
      err_q  <= err_d;
    end
  end

endmodule

// ===== rtl/dntw_queue.sv =====
// Small bundle queue between the parser and the result serializer.
`timescale 1ns / 1ps

module dntw_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dntw_pkg::bundle_t push_data_i,
  input  logic              pop_i,
  output dntw_pkg::bundle_t head_o,
  output logic              empty_o,
  output logic              full_o
);

  import dntw_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bundle_t            entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/dntw_back.sv =====
// Result serializer: walks the head bundle into the output register.
`timescale 1ns / 1ps

module dntw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dntw_pkg::bundle_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dntw_pkg::result_t out_res_o,
  output logic              out_last_o
);

  import dntw_pkg::*;

  logic       out_valid_q, out_valid_d;
  result_t    out_res_q;
  logic       out_last_q;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       is_end;

  assign load   = !out_valid_q || out_ready_i;
  assign is_end = (idx_q == head_i.last_idx);
  assign pop_o  = load && !empty_i && is_end;

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        idx_d = is_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      out_res_q  <= head_i.res[idx_q];
      out_last_q <= is_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/dns_name_text_to_wire.sv =====
// Top level: domain name text to wire format converter, stream in and out.
// A character's results are registered in the bundle queue, then loaded into the output register.
// Throughput: one character per cycle while each yields at most one result and the sink is
// ready; the output register emits one result per cycle while the sink is ready, so a name
// end with up to four results holds the output side while the bundle queue (QUEUE_DEPTH entries) absorbs input.
// Reset: asynchronous active low; clears parser state, queue pointers and output valid.
`timescale 1ns / 1ps
`include "dns_name_text_to_wire_defines.svh"

module dns_name_text_to_wire #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] offset, [15:8] value,
                                        // [24:16] total_length, [27:25] error_code
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o
);

  import dntw_pkg::*;

  logic    accept;
  logic    q_push;
  logic    q_pop;
  logic    q_empty;
  logic    q_full;
  bundle_t push_bundle;
  bundle_t head_bundle;
  result_t out_res;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && !q_full;

  dntw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .push_o   (q_push),
    .bundle_o (push_bundle)
  );

  dntw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_bundle),
    .pop_i       (q_pop),
    .head_o      (head_bundle),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  dntw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_bundle),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, out_res.error_code, out_res.total_length,
                           out_res.value, out_res.offset};
  assign m_axis_tuser_o = out_res.kind;

  `DNTW_ASSERT(a_no_push_when_full, !(q_push && q_full))
  `DNTW_ASSERT_NEXT(a_push_fills_queue, q_push, !q_empty)
  `DNTW_ASSERT(a_done_ends_run, !(m_axis_tvalid_o && out_res.kind == KIND_DONE) || m_axis_tlast_o)
  `DNTW_ASSERT(a_error_has_code,
               !(m_axis_tvalid_o && out_res.kind == KIND_ERROR) ||
               (m_axis_tlast_o && out_res.error_code != ERR_NONE))

endmodule

// ===== tb/sv/dns_name_text_to_wire_test.sv =====
// Self-checking stream testbench for the domain name text to wire converter.
`timescale 1ns / 1ps

module dns_name_text_to_wire_test;
  import dntw_pkg::*;

  localparam int ITEMS_TARGET = 460;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] offset;
    logic [7:0] value;
    logic [8:0] total;
    logic [2:0] err;
    logic       fin;
  } wire_write_t;

  typedef struct {
    logic [7:0]  ch;
    logic        is_last;
    int          n_typed;
    wire_write_t w0;
    wire_write_t w1;
  } script_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       is_last;
  } text_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  wire_write_t writes_due[$];
  wire_write_t step_writes[$];
  script_row_t script[$];
  text_char_t  name_q[$];

  mode_e       parse_st;
  logic [8:0]  lbl_slot;
  logic [8:0]  wr_pos;
  logic [9:0]  esc_acc;
  logic [2:0]  first_err;

  int mismatches = 0;
  int writes_checked = 0;
  int chars_sent = 0;
  int names_sent = 0;
  int burst_left = 0;
  int long_holds = 0;
  int cycle_count = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  bit hold_request = 1'b0;

  dns_name_text_to_wire uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic wire_write_t mk_write(kind_e k, logic [7:0] off, logic [7:0] val,
                                           logic [8:0] tot, logic [2:0] err, logic fin);
    wire_write_t w;
    w.kind   = k;
    w.offset = off;
    w.value  = val;
    w.total  = tot;
    w.err    = err;
    w.fin    = fin;
    return w;
  endfunction

  function automatic void reset_parser();
    parse_st  = MODE_NORMAL;
    lbl_slot  = 9'd0;
    wr_pos    = 9'd1;
    esc_acc   = 10'd0;
    first_err = ERR_NONE;
  endfunction

  task automatic parse_char(input logic [7:0] ch, input logic is_last);
    logic [8:0] lab_len;
    int         dec_val;
    logic       is_digit;
    logic       root_name;
    step_writes.delete();
    is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    root_name = is_last && ch == CH_DOT && first_err == ERR_NONE &&
                parse_st == MODE_NORMAL && wr_pos == 9'd1 && lbl_slot == 9'd0;
    if (root_name) begin
      step_writes.push_back(mk_write(KIND_LEN, 8'd0, 8'd0, 9'd0, ERR_NONE, 1'b0));
      step_writes.push_back(mk_write(KIND_DONE, 8'd0, 8'd0, 9'd1, ERR_NONE, 1'b0));
    end else begin
      if (first_err == ERR_NONE) begin
        case (parse_st)
          MODE_NORMAL: begin
            if (wr_pos >= 9'(NAME_MAX)) begin
              first_err = ERR_NAME_LONG;
            end else if (ch == CH_DOT) begin
              if (wr_pos == lbl_slot + 9'd1) begin
                first_err = ERR_EMPTY;
              end else begin
                lab_len = wr_pos - lbl_slot - 9'd1;
                if (lab_len > 9'(LABEL_MAX)) begin
                  first_err = ERR_LABEL_LONG;
                end else begin
                  step_writes.push_back(mk_write(KIND_LEN, lbl_slot[7:0], lab_len[7:0],
                                                 9'd0, ERR_NONE, 1'b0));
                  lbl_slot = wr_pos;
                  wr_pos   = wr_pos + 9'd1;
                end
              end
            end else if (ch == CH_BSL) begin
              parse_st = MODE_ESC;
            end else begin
              step_writes.push_back(mk_write(KIND_DATA, wr_pos[7:0], ch, 9'd0, ERR_NONE,
                                             1'b0));
              wr_pos = wr_pos + 9'd1;
            end
          end
          MODE_ESC: begin
            if (is_digit) begin
              esc_acc  = 10'(ch - CH_ZERO);
              parse_st = MODE_DIG1;
            end else begin
              step_writes.push_back(mk_write(KIND_DATA, wr_pos[7:0], ch, 9'd0, ERR_NONE,
                                             1'b0));
              wr_pos   = wr_pos + 9'd1;
              parse_st = MODE_NORMAL;
            end
          end
          MODE_DIG1: begin
            if (is_digit) begin
              esc_acc  = 10'((int'(esc_acc) * 10 + int'(ch - CH_ZERO)) & 'h3FF);
              parse_st = MODE_DIG2;
            end else begin
              first_err = ERR_BAD_ESC;
            end
          end
          default: begin
            if (is_digit) begin
              dec_val = int'(esc_acc) * 10 + int'(ch - CH_ZERO);
              step_writes.push_back(mk_write(KIND_DATA, wr_pos[7:0],
                                             (dec_val > 255) ? 8'd0 : 8'(dec_val),
                                             9'd0, ERR_NONE, 1'b0));
              wr_pos   = wr_pos + 9'd1;
              parse_st = MODE_NORMAL;
              esc_acc  = 10'd0;
            end else begin
              first_err = ERR_BAD_ESC;
            end
          end
        endcase
      end
      if (is_last) begin
        if (first_err == ERR_NONE && parse_st != MODE_NORMAL) first_err = ERR_BAD_ESC;
        if (first_err == ERR_NONE && wr_pos != lbl_slot + 9'd1) begin
          lab_len = wr_pos - lbl_slot - 9'd1;
          if (lab_len > 9'(LABEL_MAX)) begin
            first_err = ERR_LABEL_LONG;
          end else begin
            step_writes.push_back(mk_write(KIND_LEN, lbl_slot[7:0], lab_len[7:0], 9'd0,
                                           ERR_NONE, 1'b0));
            lbl_slot = wr_pos;
          end
        end
        if (first_err == ERR_NONE && lbl_slot + 9'd1 > 9'(NAME_MAX)) first_err = ERR_NAME_LONG;
        if (first_err == ERR_NONE) begin
          step_writes.push_back(mk_write(KIND_LEN, lbl_slot[7:0], 8'd0, 9'd0, ERR_NONE, 1'b0));
          step_writes.push_back(mk_write(KIND_DONE, 8'd0, 8'd0, lbl_slot + 9'd1, ERR_NONE,
                                         1'b0));
        end else begin
          step_writes.delete();
          step_writes.push_back(mk_write(KIND_ERROR, 8'd0, 8'd0, 9'd0, first_err, 1'b0));
        end
      end
    end
    if (step_writes.size() > 0) step_writes[step_writes.size() - 1].fin = 1'b1;
    if (is_last) reset_parser();
  endtask

  task automatic flag_mismatch(string field, int got, int want);
    mismatches++;
    if (mismatches <= 40)
      $display("write %0d: %s is %0d, expected %0d", writes_checked, field, got, want);
  endtask

  // Offer one character with bursty pacing, then predict and queue its writes.
  task automatic feed_char(logic [7:0] ch, logic is_last, int n_typed,
                           wire_write_t w0, wire_write_t w1);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tlast_i  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    chars_sent++;
    if (is_last) names_sent++;
    parse_char(ch, is_last);
    if (n_typed > 0) begin
      writes_due.push_back(w0);
      if (n_typed > 1) writes_due.push_back(w1);
    end else begin
      foreach (step_writes[k]) writes_due.push_back(step_writes[k]);
    end
  endtask

  function automatic void put_row(logic [7:0] ch, logic is_last, int n_typed,
                                  wire_write_t w0, wire_write_t w1);
    script.push_back('{ch, is_last, n_typed, w0, w1});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_row(s[i], i == s.len() - 1, 0, '0, '0);
  endfunction

  function automatic void push_char(logic [7:0] ch);
    name_q.push_back('{ch, 1'b0});
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == CH_DOT || v == CH_BSL);
    return v;
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v >= CH_ZERO && v <= CH_NINE);
    return v;
  endfunction

  function automatic logic [7:0] digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic void build_label(int nbytes, int esc_pct);
    int r;
    for (int i = 0; i < nbytes; i++) begin
      r = $urandom_range(0, 99);
      if (r < esc_pct / 2) begin
        push_char(CH_BSL);
        push_char(non_digit());
      end else if (r < esc_pct) begin
        push_char(CH_BSL);
        repeat (3) push_char(digit());
      end else begin
        push_char(plain_byte());
      end
    end
  endfunction

  function automatic void build_long_name(int wire_len);
    int remaining;
    int len;
    remaining = wire_len - 1;
    while (remaining > 0) begin
      len = (remaining - 1 > 63) ? 63 : remaining - 1;
      if (remaining - len - 1 == 1) len--;
      if (remaining != wire_len - 1) push_char(CH_DOT);
      build_label(len, 5);
      remaining -= len + 1;
    end
  endfunction

  function automatic void build_short_name();
    int r;
    int ndig;
    r = $urandom_range(0, 19);
    if (r <= 12) begin
      for (int l = $urandom_range(1, 4); l > 0; l--) begin
        build_label($urandom_range(1, 8), 30);
        if (l > 1) push_char(CH_DOT);
      end
      if ($urandom_range(0, 1) == 1) push_char(CH_DOT);
    end else if (r == 13) begin
      push_char(CH_DOT);
    end else if (r <= 15) begin
      case ($urandom_range(0, 2))
        0: begin
          push_char(CH_DOT);
          build_label($urandom_range(1, 5), 20);
        end
        1: begin
          build_label($urandom_range(1, 5), 20);
          push_char(CH_DOT);
          push_char(CH_DOT);
          build_label($urandom_range(1, 5), 20);
        end
        default: begin
          build_label($urandom_range(1, 5), 20);
          push_char(CH_DOT);
          push_char(CH_DOT);
        end
      endcase
    end else if (r <= 17) begin
      build_label($urandom_range(1, 4), 20);
      push_char(CH_BSL);
      ndig = $urandom_range(0, 2);
      repeat (ndig) push_char(digit());
      if (ndig > 0 && $urandom_range(0, 1) == 1) begin
        push_char(non_digit());
        build_label($urandom_range(0, 3), 20);
      end
    end else begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 3))
          0: push_char(CH_DOT);
          1: push_char(CH_BSL);
          2: push_char(digit());
          default: push_char(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endfunction

  initial begin : sink_pacing
    int style;
    int span;
    @(posedge clk_i);
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 80);
      repeat (span) begin
        if (hold_request) begin
          hold_request = 1'b0;
          long_holds++;
          m_axis_tready_i <= 1'b0;
          for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk_i);
        end
        case (style)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready_i <= ($urandom_range(0, 4) != 0);
          default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_writes
    wire_write_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (writes_due.size() == 0) begin
        flag_mismatch("transaction with nothing pending, kind", m_axis_tuser_o, -1);
      end else begin
        want = writes_due.pop_front();
        kind_seen[m_axis_tuser_o]++;
        if (m_axis_tuser_o != want.kind) flag_mismatch("kind", m_axis_tuser_o, want.kind);
        if (m_axis_tdata_o[7:0] != want.offset)
          flag_mismatch("offset", m_axis_tdata_o[7:0], want.offset);
        if (m_axis_tdata_o[15:8] != want.value)
          flag_mismatch("value", m_axis_tdata_o[15:8], want.value);
        if (m_axis_tdata_o[24:16] != want.total)
          flag_mismatch("total_length", m_axis_tdata_o[24:16], want.total);
        if (m_axis_tdata_o[27:25] != want.err)
          flag_mismatch("error_code", m_axis_tdata_o[27:25], want.err);
        if (m_axis_tdata_o[31:28] != 4'd0)
          flag_mismatch("tdata padding", m_axis_tdata_o[31:28], 0);
        if (m_axis_tlast_o != want.fin) flag_mismatch("tlast", m_axis_tlast_o, want.fin);
        writes_checked++;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int name_no;
    reset_parser();
    put_row(CH_DOT, 1'b1, 2, mk_write(KIND_LEN, 8'd0, 8'd0, 9'd0, ERR_NONE, 1'b0),
            mk_write(KIND_DONE, 8'd0, 8'd0, 9'd1, ERR_NONE, 1'b1));
    put_row("a", 1'b0, 1, mk_write(KIND_DATA, 8'd1, "a", 9'd0, ERR_NONE, 1'b1), '0);
    put_row(CH_DOT, 1'b1, 0, '0, '0);
    put_row(CH_DOT, 1'b0, 0, '0, '0);
    put_row(CH_DOT, 1'b1, 1, mk_write(KIND_ERROR, 8'd0, 8'd0, 9'd0, ERR_EMPTY, 1'b1), '0);
    put_row(8'h00, 1'b0, 1, mk_write(KIND_DATA, 8'd1, 8'h00, 9'd0, ERR_NONE, 1'b1), '0);
    put_row(8'hFF, 1'b1, 0, '0, '0);
    put_row(CH_BSL, 1'b1, 1, mk_write(KIND_ERROR, 8'd0, 8'd0, 9'd0, ERR_BAD_ESC, 1'b1), '0);
    put_text("\\300\\255\\.");
    put_row(CH_BSL, 1'b0, 0, '0, '0);
    put_row("1", 1'b0, 0, '0, '0);
    put_row("a", 1'b1, 1, mk_write(KIND_ERROR, 8'd0, 8'd0, 9'd0, ERR_BAD_ESC, 1'b1), '0);
    put_row(CH_BSL, 1'b0, 0, '0, '0);
    put_row("1", 1'b0, 0, '0, '0);
    put_row("2", 1'b1, 1, mk_write(KIND_ERROR, 8'd0, 8'd0, 9'd0, ERR_BAD_ESC, 1'b1), '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i])
      feed_char(script[i].ch, script[i].is_last, script[i].n_typed, script[i].w0,
                script[i].w1);

    name_no = 0;
    while (name_no < 6 || chars_sent < ITEMS_TARGET) begin
      name_q.delete();
      case (name_no)
        1:  build_long_name(255);
        3:  build_label($urandom_range(64, 66), 10);
        5:  build_long_name($urandom_range(256, 262));
        default: build_short_name();
      endcase
      if (name_no == 1 || name_no == 5) hold_request = 1'b1;
      name_q[name_q.size() - 1].is_last = 1'b1;
      foreach (name_q[i]) feed_char(name_q[i].ch, name_q[i].is_last, 0, '0, '0);
      name_no++;
    end
    s_axis_tvalid_i <= 1'b0;

    while (writes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("fed %0d characters in %0d names, checked %0d wire writes in %0d cycles",
             chars_sent, names_sent, writes_checked, cycle_count);
    $display("data %0d, length %0d, done %0d, error %0d; long sink holds %0d",
             kind_seen[KIND_DATA], kind_seen[KIND_LEN], kind_seen[KIND_DONE],
             kind_seen[KIND_ERROR], long_holds);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dntw_pkg.sv
rtl/dntw_front.sv
rtl/dntw_queue.sv
rtl/dntw_back.sv
rtl/dns_name_text_to_wire.sv
tb/sv/dns_name_text_to_wire_test.sv
